@@ hw/rtl/hom_pkg.sv @@
// ----------------------------------------------------------------------------
// hom_pkg: shared types and constants of the heartbeat offline monitor
// Holds the beat formats, the link between chain cells, the device rate
// classes and the register and level codes.
// ----------------------------------------------------------------------------
package hom_pkg;

  localparam int NUM_DEVICES = 11;
  localparam int COUNT_WIDTH = 16;
  localparam int DEV_ID_W    = 4;
  localparam int TICK_W      = 32;
  localparam int LEVEL_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = (COUNT_WIDTH > NUM_DEVICES) ? COUNT_WIDTH : NUM_DEVICES;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic CMD_BEAT = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REMOTE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FAST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOW    = 2'd3;

  localparam logic [LEVEL_W-1:0] LVL_NORMAL  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARNING = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_SERIOUS = 2'd2;

  localparam logic [NUM_DEVICES-1:0] DEV_MASK_ALL  = '1;
  localparam logic [NUM_DEVICES-1:0] SERIOUS_GROUP = 11'h03F;
  localparam logic [NUM_DEVICES-1:0] WARNING_GROUP = 11'h7C0;

  localparam logic [COUNT_WIDTH-1:0] MIN_REMOTE_RST = COUNT_WIDTH'(72);
  localparam logic [COUNT_WIDTH-1:0] MIN_FAST_RST   = COUNT_WIDTH'(1000);
  localparam logic [COUNT_WIDTH-1:0] MIN_SLOW_RST   = COUNT_WIDTH'(100);

  typedef enum logic [1:0] {
    CLASS_REMOTE,
    CLASS_FAST,
    CLASS_SLOW
  } rate_class_t;

  localparam rate_class_t RATE_CLASS [NUM_DEVICES] = '{
    CLASS_REMOTE, CLASS_FAST, CLASS_FAST, CLASS_FAST, CLASS_FAST,
    CLASS_SLOW, CLASS_SLOW, CLASS_FAST, CLASS_FAST, CLASS_FAST, CLASS_SLOW
  };

  typedef struct packed {
    logic                command;
    logic [DEV_ID_W-1:0] device_id;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_DEVICES-1:0] offline_mask;
    logic [LEVEL_W-1:0]     alarm_level;
    logic                   serious_flag;
    logic [TICK_W-1:0]      tick_count;
  } out_beat_t;

  typedef struct packed {
    logic                   valid;
    logic                   command;
    logic [DEV_ID_W-1:0]    device_id;
    logic [NUM_DEVICES-1:0] offline_mask;
  } link_t;

endpackage

@@ hw/rtl/hom_cell.sv @@
// ----------------------------------------------------------------------------
// hom_cell: one device slot of the monitor chain
// Keeps the saturating heartbeat counter of one device, judges it when a tick
// passes and shifts its offline bit into the mask carried down the chain.
// ----------------------------------------------------------------------------
module hom_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [hom_pkg::DEV_ID_W-1:0]    cell_index,
  input  logic [hom_pkg::COUNT_WIDTH-1:0] min_count,
  input  hom_pkg::link_t                  link_in,
  output hom_pkg::link_t                  link_out
);

  logic [hom_pkg::COUNT_WIDTH-1:0] count;
  hom_pkg::link_t                  link_q;
  hom_pkg::link_t                  link_next;
  logic                            hit;
  logic                            is_tick;
  logic                            below;

  assign hit     = link_in.valid && (link_in.command == hom_pkg::CMD_BEAT)
                   && (link_in.device_id == cell_index);
  assign is_tick = link_in.valid && (link_in.command == hom_pkg::CMD_TICK);
  assign below   = count < min_count;

  always_comb begin
    link_next = link_in;
    link_next.offline_mask = {is_tick && below,
                              link_in.offline_mask[hom_pkg::NUM_DEVICES-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      if (is_tick) begin
        count <= '0;
      end else if (hit && (count != hom_pkg::COUNT_MAX)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_q.valid <= 1'b0;
    end else if (advance) begin
      link_q <= link_next;
    end
  end

  assign link_out = link_q;

endmodule

@@ hw/rtl/hom_tail.sv @@
// ----------------------------------------------------------------------------
// hom_tail: end of the monitor chain
// Turns a finished tick into a result beat with its error level and tick
// count, holds it in the output register and stalls the chain only when a
// tick reaches the end while the previous result is still waiting.
// ----------------------------------------------------------------------------
module hom_tail (
  input  logic                            clk,
  input  logic                            rst,
  input  hom_pkg::link_t                  link_in,
  input  logic [hom_pkg::NUM_DEVICES-1:0] enable_mask,
  output logic                            advance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hom_pkg::out_beat_t              out_data
);

  logic                            tail_tick;
  logic                            load;
  logic [hom_pkg::NUM_DEVICES-1:0] active;
  logic [hom_pkg::LEVEL_W-1:0]     level_next;
  logic [hom_pkg::TICK_W-1:0]      tick_reg;
  logic [hom_pkg::TICK_W-1:0]      tick_next;
  hom_pkg::out_beat_t              out_q;

  assign tail_tick = link_in.valid && (link_in.command == hom_pkg::CMD_TICK);
  assign advance   = !(tail_tick && out_valid && !out_ready);
  assign load      = tail_tick && advance;
  assign active    = link_in.offline_mask & enable_mask;
  assign tick_next = tick_reg + 1'b1;

  always_comb begin
    if ((active & hom_pkg::SERIOUS_GROUP) != '0) begin
      level_next = hom_pkg::LVL_SERIOUS;
    end else if ((active & hom_pkg::WARNING_GROUP) != '0) begin
      level_next = hom_pkg::LVL_WARNING;
    end else begin
      level_next = hom_pkg::LVL_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tick_reg  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      tick_reg  <= tick_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q.offline_mask <= link_in.offline_mask;
      out_q.alarm_level  <= level_next;
      out_q.serious_flag <= (level_next == hom_pkg::LVL_SERIOUS);
      out_q.tick_count   <= tick_next;
    end
  end

  assign out_data = out_q;

  property p_result_from_tick;
    @(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(tail_tick);
  endproperty
  a_result_from_tick: assert property (p_result_from_tick)
    else $error("result beat appeared without a tick at the chain end");

  property p_tick_count_steps;
    @(posedge clk) disable iff (rst)
      load |=> (out_data.tick_count == tick_reg) && out_valid;
  endproperty
  a_tick_count_steps: assert property (p_tick_count_steps)
    else $error("result tick count does not match the tick register");

  property p_stall_only_when_blocked;
    @(posedge clk) disable iff (rst)
      !advance |-> (out_valid && !out_ready && tail_tick);
  endproperty
  a_stall_only_when_blocked: assert property (p_stall_only_when_blocked)
    else $error("chain stalled without a blocked result");

  property p_level_flag;
    @(posedge clk) disable iff (rst)
      out_valid |-> (out_data.serious_flag == (out_data.alarm_level == hom_pkg::LVL_SERIOUS))
                    && (out_data.alarm_level <= hom_pkg::LVL_SERIOUS);
  endproperty
  a_level_flag: assert property (p_level_flag)
    else $error("error level and serious flag disagree");

endmodule

@@ hw/rtl/heartbeat_offline_monitor.sv @@
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor: eleven-device heartbeat watchdog
// Counts heartbeats per device and reports offline devices and an error
// level on every judge tick.
// ----------------------------------------------------------------------------
// Each accepted beat walks a chain of eleven cells, one per device, one cell
// per cycle while the chain is not stalled; a cell counts its device's
// heartbeats and, when a tick passes, adds its offline bit to the mask and
// clears its count. A new beat is taken every cycle unless input is held off,
// and a tick's result is registered in the first cell at the edge that
// accepts it, then in each of the other ten cells in turn, then in the output
// register. Input is held off only while a tick has reached the end of the
// chain and the previous result is not yet taken.
// ----------------------------------------------------------------------------
module heartbeat_offline_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hom_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hom_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [hom_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hom_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [hom_pkg::NUM_DEVICES-1:0] enable_mask;
  logic [hom_pkg::COUNT_WIDTH-1:0] min_count_remote;
  logic [hom_pkg::COUNT_WIDTH-1:0] min_count_fast;
  logic [hom_pkg::COUNT_WIDTH-1:0] min_count_slow;
  logic                            advance;
  hom_pkg::link_t                  links [hom_pkg::NUM_DEVICES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask      <= hom_pkg::DEV_MASK_ALL;
      min_count_remote <= hom_pkg::MIN_REMOTE_RST;
      min_count_fast   <= hom_pkg::MIN_FAST_RST;
      min_count_slow   <= hom_pkg::MIN_SLOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hom_pkg::CFG_ENABLE_MASK: enable_mask <= cfg_wdata[hom_pkg::NUM_DEVICES-1:0];
        hom_pkg::CFG_MIN_REMOTE:  min_count_remote <= cfg_wdata[hom_pkg::COUNT_WIDTH-1:0];
        hom_pkg::CFG_MIN_FAST:    min_count_fast <= cfg_wdata[hom_pkg::COUNT_WIDTH-1:0];
        hom_pkg::CFG_MIN_SLOW:    min_count_slow <= cfg_wdata[hom_pkg::COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = advance;

  always_comb begin
    links[0].valid        = in_valid;
    links[0].command      = in_data.command;
    links[0].device_id    = in_data.device_id;
    links[0].offline_mask = '0;
  end

  for (genvar i = 0; i < hom_pkg::NUM_DEVICES; i++) begin : g_cell
    logic [hom_pkg::COUNT_WIDTH-1:0] min_sel;

    always_comb begin
      case (hom_pkg::RATE_CLASS[i])
        hom_pkg::CLASS_REMOTE: min_sel = min_count_remote;
        hom_pkg::CLASS_FAST:   min_sel = min_count_fast;
        default:               min_sel = min_count_slow;
      endcase
    end

    hom_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (hom_pkg::DEV_ID_W'(i)),
      .min_count  (min_sel),
      .link_in    (links[i]),
      .link_out   (links[i+1])
    );
  end

  hom_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .link_in     (links[hom_pkg::NUM_DEVICES]),
    .enable_mask (enable_mask),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the heartbeat offline monitor
// Sends heartbeats and judge ticks through the input channel and keeps a
// cycle-free model of the per-device counters, the rate class minimums and
// the level priority. Every report beat is compared field by field with the
// oldest predicted report. The run covers directed corner cases, counts right
// at the class minimums, and random traffic under several register settings
// and stall mixes.
// ----------------------------------------------------------------------------
module tb;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  hom_pkg::in_beat_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  hom_pkg::out_beat_t             out_data;
  logic                           cfg_we;
  logic [hom_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hom_pkg::CFG_DATA_W-1:0] cfg_wdata;

  heartbeat_offline_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [hom_pkg::COUNT_WIDTH-1:0] beat_count [hom_pkg::NUM_DEVICES];
  logic [hom_pkg::NUM_DEVICES-1:0] mdl_enable;
  logic [hom_pkg::COUNT_WIDTH-1:0] mdl_min_remote;
  logic [hom_pkg::COUNT_WIDTH-1:0] mdl_min_fast;
  logic [hom_pkg::COUNT_WIDTH-1:0] mdl_min_slow;
  logic [hom_pkg::TICK_W-1:0]      mdl_ticks;
  hom_pkg::out_beat_t              pending_reports [$];

  int send_idle_pct;
  int recv_idle_pct;
  int n_errors;
  int n_beats;
  int n_ticks;
  int n_reports;
  int n_configs;

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_errors++;
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  task automatic watchdog_predict(hom_pkg::in_beat_t b);
    hom_pkg::out_beat_t              r;
    logic [hom_pkg::NUM_DEVICES-1:0] active;
    logic [hom_pkg::COUNT_WIDTH-1:0] floor_val;
    if (b.command == hom_pkg::CMD_BEAT) begin
      n_beats++;
      if (b.device_id < hom_pkg::NUM_DEVICES
          && beat_count[b.device_id] != hom_pkg::COUNT_MAX) begin
        beat_count[b.device_id]++;
      end
    end else begin
      n_ticks++;
      mdl_ticks++;
      r = '0;
      for (int d = 0; d < hom_pkg::NUM_DEVICES; d++) begin
        case (hom_pkg::RATE_CLASS[d])
          hom_pkg::CLASS_REMOTE: floor_val = mdl_min_remote;
          hom_pkg::CLASS_FAST:   floor_val = mdl_min_fast;
          default:               floor_val = mdl_min_slow;
        endcase
        if (beat_count[d] < floor_val) begin
          r.offline_mask[d] = 1'b1;
        end
        beat_count[d] = '0;
      end
      active = r.offline_mask & mdl_enable;
      if (|(active & hom_pkg::SERIOUS_GROUP)) begin
        r.alarm_level = hom_pkg::LVL_SERIOUS;
      end else if (|(active & hom_pkg::WARNING_GROUP)) begin
        r.alarm_level = hom_pkg::LVL_WARNING;
      end else begin
        r.alarm_level = hom_pkg::LVL_NORMAL;
      end
      r.serious_flag = (r.alarm_level == hom_pkg::LVL_SERIOUS);
      r.tick_count = mdl_ticks;
      pending_reports.push_back(r);
    end
  endtask

  always @(posedge clk) begin : check_reports
    hom_pkg::out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none pending, tick_count", '0, out_data.tick_count);
      end else begin
        want = pending_reports.pop_front();
        n_reports++;
        if (out_data.offline_mask !== want.offline_mask)
          report_mismatch("offline_mask", 32'(want.offline_mask),
                          32'(out_data.offline_mask));
        if (out_data.alarm_level !== want.alarm_level)
          report_mismatch("alarm_level", 32'(want.alarm_level), 32'(out_data.alarm_level));
        if (out_data.serious_flag !== want.serious_flag)
          report_mismatch("serious_flag", 32'(want.serious_flag),
                          32'(out_data.serious_flag));
        if (out_data.tick_count !== want.tick_count)
          report_mismatch("tick_count", want.tick_count, out_data.tick_count);
      end
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_item(logic cmd, logic [hom_pkg::DEV_ID_W-1:0] dev);
    hom_pkg::in_beat_t b;
    b.command = cmd;
    b.device_id = dev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    watchdog_predict(b);
    @(negedge clk);
  endtask

  // Heartbeats still walking the chain give no report, so wait out its depth.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(logic [hom_pkg::NUM_DEVICES-1:0] en,
                            logic [hom_pkg::COUNT_WIDTH-1:0] rem,
                            logic [hom_pkg::COUNT_WIDTH-1:0] fast,
                            logic [hom_pkg::COUNT_WIDTH-1:0] slow);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= hom_pkg::CFG_ENABLE_MASK;
    cfg_wdata <= hom_pkg::CFG_DATA_W'(en);
    @(negedge clk);
    cfg_index <= hom_pkg::CFG_MIN_REMOTE;
    cfg_wdata <= hom_pkg::CFG_DATA_W'(rem);
    @(negedge clk);
    cfg_index <= hom_pkg::CFG_MIN_FAST;
    cfg_wdata <= hom_pkg::CFG_DATA_W'(fast);
    @(negedge clk);
    cfg_index <= hom_pkg::CFG_MIN_SLOW;
    cfg_wdata <= hom_pkg::CFG_DATA_W'(slow);
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_enable = en;
    mdl_min_remote = rem;
    mdl_min_fast = fast;
    mdl_min_slow = slow;
    n_configs++;
  endtask

  function automatic logic [hom_pkg::COUNT_WIDTH-1:0] random_minimum();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return hom_pkg::COUNT_MAX;
      default: return hom_pkg::COUNT_WIDTH'($urandom_range(0, 5));
    endcase
  endfunction

  // With the reset minimums no device has beaten yet, so all are offline.
  task automatic test_reset_values;
    send_item(hom_pkg::CMD_TICK, '0);
  endtask

  task automatic test_directed_cases;
    set_config(hom_pkg::DEV_MASK_ALL, hom_pkg::COUNT_WIDTH'(1), hom_pkg::COUNT_WIDTH'(1),
               hom_pkg::COUNT_WIDTH'(1));
    for (int d = 0; d < hom_pkg::NUM_DEVICES; d++) begin
      send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(d));
    end
    send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(11));
    send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(15));
    send_item(hom_pkg::CMD_TICK, hom_pkg::DEV_ID_W'(15));
    set_config(hom_pkg::WARNING_GROUP, hom_pkg::COUNT_WIDTH'(1), hom_pkg::COUNT_WIDTH'(1),
               hom_pkg::COUNT_WIDTH'(1));
    send_item(hom_pkg::CMD_TICK, '0);
    set_config('0, hom_pkg::COUNT_MAX, hom_pkg::COUNT_MAX, hom_pkg::COUNT_MAX);
    send_item(hom_pkg::CMD_TICK, '0);
    set_config(hom_pkg::DEV_MASK_ALL, '0, '0, '0);
    send_item(hom_pkg::CMD_TICK, '0);
    // Only the feeder is enabled while the pitch motor is the one that beat.
    set_config(hom_pkg::NUM_DEVICES'(1 << 9), '0, hom_pkg::COUNT_WIDTH'(1), '0);
    send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(7));
    send_item(hom_pkg::CMD_TICK, '0);
  endtask

  // Remote stops one short of its minimum, fast reaches it, slow does each.
  task automatic test_count_threshold;
    set_config(hom_pkg::DEV_MASK_ALL, hom_pkg::COUNT_WIDTH'(200), hom_pkg::COUNT_WIDTH'(100),
               hom_pkg::COUNT_WIDTH'(50));
    for (int i = 0; i < 199; i++) begin
      send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(0));
    end
    for (int i = 0; i < 100; i++) begin
      send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(1));
    end
    for (int i = 0; i < 49; i++) begin
      send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(5));
    end
    for (int i = 0; i < 50; i++) begin
      send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'(6));
    end
    send_item(hom_pkg::CMD_TICK, '0);
    send_item(hom_pkg::CMD_TICK, '0);
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct, int n_items);
    logic [hom_pkg::NUM_DEVICES-1:0] en;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int blk = 0; blk < 3; blk++) begin
      case ($urandom_range(0, 3))
        0:       en = '0;
        1:       en = hom_pkg::DEV_MASK_ALL;
        default: en = hom_pkg::NUM_DEVICES'($urandom_range(0, 2047));
      endcase
      set_config(en, random_minimum(), random_minimum(), random_minimum());
      for (int i = 0; i < n_items / 3; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(hom_pkg::CMD_TICK, hom_pkg::DEV_ID_W'($urandom_range(0, 15)));
        end else begin
          send_item(hom_pkg::CMD_BEAT, hom_pkg::DEV_ID_W'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int d = 0; d < hom_pkg::NUM_DEVICES; d++) begin
      beat_count[d] = '0;
    end
    mdl_enable = hom_pkg::DEV_MASK_ALL;
    mdl_min_remote = hom_pkg::MIN_REMOTE_RST;
    mdl_min_fast = hom_pkg::MIN_FAST_RST;
    mdl_min_slow = hom_pkg::MIN_SLOW_RST;
    mdl_ticks = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_errors = 0;
    n_beats = 0;
    n_ticks = 0;
    n_reports = 0;
    n_configs = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_cases();
    test_count_threshold();
    test_random_traffic(10, 72, 500);
    test_random_traffic(72, 10, 500);
    test_random_traffic(0, 0, 500);
    drain();

    $display("Sent %0d heartbeats and %0d judge ticks across %0d register settings.",
             n_beats, n_ticks, n_configs);
    $display("Checked %0d reports, %0d mismatches.", n_reports, n_errors);
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("[heartbeat_offline_monitor] OK");
    end else begin
      $display("[heartbeat_offline_monitor] ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out with %0d reports still pending.", pending_reports.size());
    $display("[heartbeat_offline_monitor] ERROR");
    $finish;
  end

endmodule
